[rtl/bva_pkg.sv]
package bva_pkg;

   // Field and datapath widths.
   localparam int MV_W      = 15;
   localparam int PHASE_W   = 7;
   localparam int COUNT_W   = 17;
   localparam int WARN_W    = 15;
   localparam int TPS_W     = 16;
   localparam int BDIV_W    = 10;
   localparam int RSP_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Beeper level divider geometry: a 16-bit quotient, two quotient bits per cycle.
   localparam int DVD_W     = 25;
   localparam int DVR_W     = 10;
   localparam int QUO_W     = 16;
   localparam int DIV_STEPS = 2;
   localparam int DIV_CYC   = QUO_W / DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_CYC);

   // Arithmetic constants.
   localparam int SCALE_MUL_W = 14;
   localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(9872);
   localparam int SCALE_DIV = 579;
   localparam int FILT_DIV  = 30;
   // Smallest dividend whose quotient is the largest 15-bit voltage.
   localparam logic [DVD_W-1:0]       SCALE_SAT = DVD_W'(SCALE_DIV * 32767);
   localparam logic [4:0]             FILT_MUL  = 5'd29;
   localparam logic [MV_W-1:0]        BEEP_BASE_MV = MV_W'(9000);
   localparam logic [COUNT_W-1:0]     COUNT_STEP_DOWN = COUNT_W'(5);
   localparam logic [COUNT_W-1:0]     COUNT_FLOOR     = COUNT_W'(10);

   // The fixed divisions are done by multiplying with a rounded-up reciprocal.
   // With the shift at least the dividend width plus the divisor's bit length,
   // the shifted product is the exact truncated quotient over the whole range.
   localparam int SCALE_SHIFT   = 35;
   localparam int SCALE_RECIP_W = 26;
   localparam int SCALE_PROD_W  = DVD_W + SCALE_RECIP_W;
   localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP =
      SCALE_RECIP_W'(((64'd1 << SCALE_SHIFT) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV));
   localparam int FILT_DVD_W    = 20;
   localparam int FILT_SHIFT    = 25;
   localparam int FILT_RECIP_W  = 21;
   localparam int FILT_PROD_W   = FILT_DVD_W + FILT_RECIP_W;
   localparam logic [FILT_RECIP_W-1:0] FILT_RECIP =
      FILT_RECIP_W'(((64'd1 << FILT_SHIFT) + 64'(FILT_DIV - 1)) / 64'(FILT_DIV));

   // Reset values.
   localparam logic [WARN_W-1:0]  WARN_RESET  = WARN_W'(10000);
   localparam logic [TPS_W-1:0]   TPS_RESET   = TPS_W'(1000);
   localparam logic [BDIV_W-1:0]  BDIV_RESET  = BDIV_W'(100);
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1000);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WARN_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SEC  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_DIVISOR   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SUM,
      ST_FILTER,
      ST_LEVEL,
      ST_LEVEL_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load_sample;
      logic        cap_scaled;
      logic        cap_sum;
      logic        cap_filtered;
      logic        div_start;
      logic        cap_level;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

[rtl/bva_divider.sv]
module bva_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bva_pkg::DVD_W-1:0]    dividend,
   input  logic [bva_pkg::DVR_W-1:0]    divisor,
   output logic                         done,
   output logic [bva_pkg::QUO_W-1:0]    quotient
);

   logic [bva_pkg::DVR_W-1:0]     rem_ff, rem_in, rem_v;
   logic [bva_pkg::QUO_W-1:0]     sh_ff, sh_in, sh_v;
   logic [bva_pkg::DVR_W-1:0]     dvr_ff, dvr_in;
   logic [bva_pkg::DIV_CNT_W-1:0] count_ff, count_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [bva_pkg::DVR_W:0]       trial;
   logic                          qbit;

   // The dividend is always below divisor * 2^16, so its upper bits start the
   // partial remainder and only the lower sixteen bits are shifted through.
   always_comb begin
      rem_v = rem_ff;
      sh_v  = sh_ff;
      trial = '0;
      qbit  = 1'b0;
      for (int i = 0; i < bva_pkg::DIV_STEPS; i++) begin
         trial = {rem_v, sh_v[bva_pkg::QUO_W-1]};
         if (trial >= {1'b0, dvr_ff}) begin
            rem_v = bva_pkg::DVR_W'(trial - {1'b0, dvr_ff});
            qbit  = 1'b1;
         end else begin
            rem_v = trial[bva_pkg::DVR_W-1:0];
            qbit  = 1'b0;
         end
         sh_v = {sh_v[bva_pkg::QUO_W-2:0], qbit};
      end
   end

   always_comb begin
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      dvr_in   = dvr_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = bva_pkg::DVR_W'(dividend[bva_pkg::DVD_W-1:bva_pkg::QUO_W]);
         sh_in    = dividend[bva_pkg::QUO_W-1:0];
         dvr_in   = divisor;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         rem_in   = rem_v;
         sh_in    = sh_v;
         count_in = count_ff + 1'b1;
         if (count_ff == bva_pkg::DIV_CNT_W'(bva_pkg::DIV_CYC - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      dvr_ff <= dvr_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

[rtl/bva_datapath.sv]
module bva_datapath #(
   parameter int ADC_BITS    = 10,
   parameter int DUTY_PERIOD = 100
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ADC_BITS-1:0]              sample,
   input  logic                             csr_write,
   input  logic [bva_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bva_pkg::CSR_DAT_W-1:0]    csr_data,
   input  bva_pkg::cmd_type                 cmd,
   output bva_pkg::status_type              status,
   output logic [bva_pkg::RSP_W-1:0]        rsp_data
);

   localparam int ProdWidth = ADC_BITS + bva_pkg::SCALE_MUL_W;
   localparam int CmpWidth  = (ProdWidth > bva_pkg::DVD_W) ? ProdWidth : bva_pkg::DVD_W;

   logic [bva_pkg::WARN_W-1:0]  warn_ff, warn_in;
   logic [bva_pkg::TPS_W-1:0]   tps_ff, tps_in;
   logic [bva_pkg::BDIV_W-1:0]  bdiv_ff, bdiv_in;

   logic [bva_pkg::MV_W-1:0]    filtered_ff, filtered_in;
   logic [bva_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [bva_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        alarm_ff, alarm_in;
   logic                        beeper_ff, beeper_in;

   logic [ProdWidth-1:0]          prod_ff, prod_in;
   logic [bva_pkg::MV_W-1:0]      scaled_ff, scaled_in;
   logic [bva_pkg::FILT_DVD_W-1:0] sum_ff, sum_in;
   logic [bva_pkg::QUO_W-1:0]     level_ff, level_in;
   logic [bva_pkg::RSP_W-1:0]     rsp_ff, rsp_in;

   logic [CmpWidth-1:0]             prod_wide;
   logic [bva_pkg::DVD_W-1:0]       scale_dvd;
   logic [bva_pkg::SCALE_PROD_W-1:0] scale_prod;
   logic [bva_pkg::FILT_DVD_W-1:0]  filt_prod;
   logic [bva_pkg::FILT_DVD_W-1:0]  filt_dvd;
   logic [bva_pkg::FILT_PROD_W-1:0] filt_quo;
   logic                            lvl_neg;
   logic [bva_pkg::MV_W-1:0]        lvl_mag;
   logic [bva_pkg::DVR_W-1:0]       beep_dvr;
   logic [bva_pkg::DVD_W-1:0]       div_dvd;
   logic [bva_pkg::DVR_W-1:0]       div_dvr;
   logic                            div_done;
   logic [bva_pkg::QUO_W-1:0]       div_quo;

   logic [bva_pkg::PHASE_W:0]   phase_sum;
   logic [bva_pkg::PHASE_W-1:0] phase_adv;
   logic [bva_pkg::COUNT_W-1:0] limit;
   logic [bva_pkg::COUNT_W-1:0] count_nx;
   logic                        alarm_nx;
   logic                        beeper_nx;

   // Scaling and filtering by reciprocal products, and the beeper level operands.
   always_comb begin
      prod_wide  = CmpWidth'(prod_ff);
      scale_dvd  = (prod_wide > CmpWidth'(bva_pkg::SCALE_SAT)) ? bva_pkg::SCALE_SAT
                                                               : prod_wide[bva_pkg::DVD_W-1:0];
      scale_prod = bva_pkg::SCALE_PROD_W'(scale_dvd)
                   * bva_pkg::SCALE_PROD_W'(bva_pkg::SCALE_RECIP);
      filt_prod  = bva_pkg::FILT_DVD_W'(filtered_ff) * bva_pkg::FILT_DVD_W'(bva_pkg::FILT_MUL);
      filt_dvd   = filt_prod + bva_pkg::FILT_DVD_W'(scaled_ff);
      filt_quo   = bva_pkg::FILT_PROD_W'(sum_ff) * bva_pkg::FILT_PROD_W'(bva_pkg::FILT_RECIP);
      lvl_neg    = filtered_ff < bva_pkg::BEEP_BASE_MV;
      lvl_mag    = lvl_neg ? bva_pkg::BEEP_BASE_MV - filtered_ff
                           : filtered_ff - bva_pkg::BEEP_BASE_MV;
      beep_dvr   = (bdiv_ff == '0) ? bva_pkg::DVR_W'(1) : bdiv_ff;
      div_dvd    = bva_pkg::DVD_W'(lvl_mag);
      div_dvr    = beep_dvr;
   end

   bva_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvr),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done = div_done;

   // End-of-tick update: phase, hysteresis counter, alarm and beeper.
   always_comb begin
      phase_sum = {1'b0, phase_ff} + 1'b1;
      phase_adv = (phase_sum >= (bva_pkg::PHASE_W + 1)'(DUTY_PERIOD)) ? '0
                                                                      : phase_sum[bva_pkg::PHASE_W-1:0];
      limit     = {tps_ff, 1'b0};
      count_nx  = count_ff;
      alarm_nx  = alarm_ff;
      beeper_nx = beeper_ff;
      if (filtered_ff < warn_ff) begin
         if (count_ff < limit) begin
            count_nx = count_ff + 1'b1;
         end else begin
            alarm_nx = 1'b1;
         end
      end else begin
         if (count_ff > bva_pkg::COUNT_FLOOR) begin
            count_nx = count_ff - bva_pkg::COUNT_STEP_DOWN;
         end else begin
            alarm_nx  = 1'b0;
            beeper_nx = 1'b0;
         end
      end
      // A negative level truncates toward zero, so a zero quotient means level zero.
      if (alarm_nx) begin
         if (lvl_neg) begin
            beeper_nx = (level_ff != '0) || (phase_adv != '0);
         end else begin
            beeper_nx = bva_pkg::QUO_W'(phase_adv) > level_ff;
         end
      end
   end

   always_comb begin
      warn_in     = warn_ff;
      tps_in      = tps_ff;
      bdiv_in     = bdiv_ff;
      prod_in     = prod_ff;
      scaled_in   = scaled_ff;
      sum_in      = sum_ff;
      filtered_in = filtered_ff;
      level_in    = level_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      alarm_in    = alarm_ff;
      beeper_in   = beeper_ff;
      rsp_in      = rsp_ff;
      if (csr_write) begin
         unique case (csr_index)
            bva_pkg::CSR_WARN_THRESHOLD: warn_in = csr_data[bva_pkg::WARN_W-1:0];
            bva_pkg::CSR_TICKS_PER_SEC:  tps_in  = csr_data[bva_pkg::TPS_W-1:0];
            bva_pkg::CSR_BEEP_DIVISOR:   bdiv_in = csr_data[bva_pkg::BDIV_W-1:0];
            default: ;
         endcase
      end
      if (cmd.load_sample) begin
         prod_in = ProdWidth'(sample) * ProdWidth'(bva_pkg::SCALE_MUL);
      end
      if (cmd.cap_scaled) begin
         scaled_in = scale_prod[bva_pkg::SCALE_SHIFT +: bva_pkg::MV_W];
      end
      if (cmd.cap_sum) begin
         sum_in = filt_dvd;
      end
      if (cmd.cap_filtered) begin
         filtered_in = filt_quo[bva_pkg::FILT_SHIFT +: bva_pkg::MV_W];
      end
      if (cmd.cap_level) begin
         level_in = div_quo;
      end
      if (cmd.commit) begin
         phase_in  = phase_adv;
         count_in  = count_nx;
         alarm_in  = alarm_nx;
         beeper_in = beeper_nx;
         rsp_in    = bva_pkg::RSP_W'({beeper_nx, alarm_nx, filtered_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_ff     <= bva_pkg::WARN_RESET;
         tps_ff      <= bva_pkg::TPS_RESET;
         bdiv_ff     <= bva_pkg::BDIV_RESET;
         filtered_ff <= '0;
         phase_ff    <= '0;
         count_ff    <= bva_pkg::COUNT_RESET;
         alarm_ff    <= 1'b1;
         beeper_ff   <= 1'b0;
      end else begin
         warn_ff     <= warn_in;
         tps_ff      <= tps_in;
         bdiv_ff     <= bdiv_in;
         filtered_ff <= filtered_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         alarm_ff    <= alarm_in;
         beeper_ff   <= beeper_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
      sum_ff    <= sum_in;
      level_ff  <= level_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/bva_ctrl.sv]
module bva_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  bva_pkg::status_type  status,
   output bva_pkg::cmd_type     cmd
);

   bva_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in         = state_ff;
      cmd.load_sample  = 1'b0;
      cmd.cap_scaled   = 1'b0;
      cmd.cap_sum      = 1'b0;
      cmd.cap_filtered = 1'b0;
      cmd.div_start    = 1'b0;
      cmd.cap_level    = 1'b0;
      cmd.commit       = 1'b0;
      req_tready       = 1'b0;
      unique case (state_ff)
         bva_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_sample = 1'b1;
               state_in        = bva_pkg::ST_SCALE;
            end
         end
         bva_pkg::ST_SCALE: begin
            cmd.cap_scaled = 1'b1;
            state_in       = bva_pkg::ST_SUM;
         end
         bva_pkg::ST_SUM: begin
            cmd.cap_sum = 1'b1;
            state_in    = bva_pkg::ST_FILTER;
         end
         bva_pkg::ST_FILTER: begin
            cmd.cap_filtered = 1'b1;
            state_in         = bva_pkg::ST_LEVEL;
         end
         bva_pkg::ST_LEVEL: begin
            cmd.div_start = 1'b1;
            state_in      = bva_pkg::ST_LEVEL_WAIT;
         end
         bva_pkg::ST_LEVEL_WAIT: begin
            if (status.div_done) begin
               cmd.cap_level = 1'b1;
               state_in      = bva_pkg::ST_FINISH;
            end
         end
         bva_pkg::ST_FINISH: begin
            // The tick's state is only committed once the output register can take it.
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = bva_pkg::ST_IDLE;
            end
         end
         default: state_in = bva_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bva_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/battery_voltage_alarm_top.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata: adc_sample
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata: battery_mv, alarm_active, beeper
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One item occupies the block from acceptance to the next acceptance: it is scaled,
// summed and filtered in turn (the fixed divisions are reciprocal products), its
// beeper level comes from the two-bit-per-cycle divider (start, eight steps,
// capture), and the tick is committed before the block accepts again.
// The result is registered on commit and waits in an output register;
// a stalled rsp holds the block in its final step until the register is free.
// Reset is synchronous; it restores the register defaults and the alarm state.
// csr_ready is always high.
module battery_voltage_alarm_top #(
   parameter int ADC_BITS    = 10,
   parameter int DUTY_PERIOD = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((ADC_BITS+7)/8)*8-1:0]     req_tdata,   // [ADC_BITS-1:0] adc_sample
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bva_pkg::RSP_W-1:0]         rsp_tdata,   // [14:0] battery_mv, [15] alarm_active,
                                                          // [16] beeper
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bva_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bva_pkg::CSR_DAT_W-1:0]     csr_data
);

   bva_pkg::cmd_type    cmd;
   bva_pkg::status_type status;

   assign csr_ready = 1'b1;

   bva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bva_datapath #(
      .ADC_BITS    (ADC_BITS),
      .DUTY_PERIOD (DUTY_PERIOD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .sample    (req_tdata[ADC_BITS-1:0]),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

   // Only one item is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is still in work");

   // The beeper is silenced whenever the alarm is disabled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15] || !rsp_tdata[16]))
      else $error("beeper on while alarm inactive");

   // A result only appears after a commit of the tick's state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result raised without a commit");

   // The divider cannot report completion right after being started.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !status.div_done)
      else $error("divider done immediately after start");

endmodule

[tb/sv/bva_checker.sv]
module bva_checker #(
   parameter int ADC_BITS    = 10,
   parameter int DUTY_PERIOD = 100
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [((ADC_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [bva_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [bva_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bva_pkg::CSR_DAT_W-1:0] csr_data,
   output int                            failures,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MV_CEILING = 32767;
   localparam int MV_BASE    = 9000;

   typedef struct packed {
      logic [14:0] battery_mv;
      logic        alarm_active;
      logic        beeper;
   } tick_result_type;

   // Settings and state as the block should hold them.
   int unsigned warn_threshold;
   int unsigned ticks_per_sec;
   int unsigned beep_div;
   int unsigned filtered_mv;
   int unsigned duty_phase;
   int unsigned warning_count;
   logic        alarm_on;
   logic        beeper_on;

   tick_result_type expected_ticks[$];
   int              mismatch_count;

   task automatic restore_defaults();
      warn_threshold = 10000;
      ticks_per_sec  = 1000;
      beep_div       = 100;
      filtered_mv    = 0;
      duty_phase     = 0;
      warning_count  = 1000;
      alarm_on       = 1'b1;
      beeper_on      = 1'b0;
   endtask

   task automatic predict_tick(input logic [ADC_BITS-1:0] sample, output tick_result_type res);
      int unsigned scaled;
      int unsigned limit;
      int          divisor;
      int          level;
      duty_phase = duty_phase + 1;
      if (duty_phase >= DUTY_PERIOD) begin
         duty_phase = 0;
      end
      scaled = int'(sample) * 9872 / 579;
      if (scaled > MV_CEILING) begin
         scaled = MV_CEILING;
      end
      filtered_mv = (filtered_mv * 29 + scaled) / 30;
      if (filtered_mv > MV_CEILING) begin
         filtered_mv = MV_CEILING;
      end
      limit = ticks_per_sec * 2;
      // Hysteresis: the count climbs while low and decays while high.
      if (filtered_mv < warn_threshold) begin
         if (warning_count < limit) begin
            warning_count = warning_count + 1;
         end else begin
            alarm_on = 1'b1;
         end
      end else begin
         if (warning_count > 10) begin
            warning_count = warning_count - 5;
         end else begin
            alarm_on  = 1'b0;
            beeper_on = 1'b0;
         end
      end
      warning_count = warning_count & 32'h1FFFF;
      if (alarm_on) begin
         divisor   = (beep_div == 0) ? 1 : int'(beep_div);
         level     = (int'(filtered_mv) - MV_BASE) / divisor;
         beeper_on = (int'(duty_phase) > level);
      end
      res.battery_mv   = filtered_mv[14:0];
      res.alarm_active = alarm_on;
      res.beeper       = beeper_on;
   endtask

   task automatic report_mismatch(input string what, input tick_result_type want,
                                  input tick_result_type got);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected mv=%0d alarm=%0b beeper=%0b, got mv=%0d alarm=%0b beeper=%0b",
                  $realtime, what, want.battery_mv, want.alarm_active, want.beeper,
                  got.battery_mv, got.alarm_active, got.beeper);
      end
   endtask

   initial begin
      restore_defaults();
      mismatch_count = 0;
      failures       = 0;
      pending        = 0;
   end

   always @(posedge clock) begin
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         restore_defaults();
         expected_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bva_pkg::CSR_WARN_THRESHOLD: warn_threshold = csr_data & 16'h7FFF;
               bva_pkg::CSR_TICKS_PER_SEC:  ticks_per_sec  = csr_data;
               bva_pkg::CSR_BEEP_DIVISOR:   beep_div       = csr_data & 16'h03FF;
               default: ;
            endcase
         end
         // Results are checked before the new item is predicted, so the
         // oldest expectation is always the one compared.
         if (rsp_tvalid && rsp_tready) begin
            got.battery_mv   = rsp_tdata[14:0];
            got.alarm_active = rsp_tdata[15];
            got.beeper       = rsp_tdata[16];
            if (expected_ticks.size() == 0) begin
               want = '0;
               report_mismatch("result with nothing expected", want, got);
            end else begin
               want = expected_ticks.pop_front();
               if (got.battery_mv !== want.battery_mv ||
                   got.alarm_active !== want.alarm_active ||
                   got.beeper !== want.beeper) begin
                  report_mismatch("result mismatch", want, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[ADC_BITS-1:0], want);
            expected_ticks.push_back(want);
         end
      end
      failures <= mismatch_count;
      pending  <= expected_ticks.size();
   end

endmodule

[tb/sv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADC_BITS    = 10;
   localparam int DUTY_PERIOD = 100;
   localparam int REQ_W       = ((ADC_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam logic [bva_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_W-1:0]              req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [bva_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [bva_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bva_pkg::CSR_DAT_W-1:0] csr_data = '0;

   int failures;
   int pending;
   int tx_idle_pct = 8;
   int rx_idle_pct = 67;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   battery_voltage_alarm_top #(
      .ADC_BITS    (ADC_BITS),
      .DUTY_PERIOD (DUTY_PERIOD)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bva_checker #(
      .ADC_BITS    (ADC_BITS),
      .DUTY_PERIOD (DUTY_PERIOD)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: random back-pressure, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen  <= hold_requests;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_sample(input int sample);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample[ADC_BITS-1:0]);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering items and waits until every tick result is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bva_pkg::CSR_IDX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[bva_pkg::CSR_DAT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Runs of samples hover around a level so that the slow filter actually
   // settles there; the odd run is pure noise.
   task automatic send_runs(input int count, input int threshold_mv);
      int sent;
      int run_len;
      int centre;
      int sample;
      int threshold_adc;
      threshold_adc = threshold_mv * 579 / 9872;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(5, 60);
         case ($urandom_range(0, 9))
            0, 1:          centre = -1;
            2, 3, 4, 5:    centre = threshold_adc;
            6:             centre = $urandom_range(520, 1023);
            default:       centre = $urandom_range(0, 1023);
         endcase
         for (int i = 0; i < run_len && sent < count; i++) begin
            if (centre < 0) begin
               sample = $urandom_range(0, 1023);
            end else begin
               sample = centre + $urandom_range(0, 40) - 20;
               if (sample < 0) sample = 0;
               if (sample > 1023) sample = 1023;
            end
            send_sample(sample);
            sent++;
         end
      end
   endtask

   task automatic run_setting(input int threshold, input int tps, input int divisor,
                              input int tx_pct, input int rx_pct, input int count,
                              input bit long_hold);
      drain();
      write_reg(bva_pkg::CSR_WARN_THRESHOLD, threshold);
      write_reg(bva_pkg::CSR_TICKS_PER_SEC, tps);
      write_reg(bva_pkg::CSR_BEEP_DIVISOR, divisor);
      csr_valid   <= 1'b0;
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
      if (long_hold) begin
         hold_requests <= hold_requests + 1;
      end
      send_runs(count, threshold & 16'h7FFF);
   endtask

   initial begin
      int directed[$];
      directed = '{0, 1023, 0, 1023, 1, 1022, 341, 682, 528, 529, 586, 587,
                   1023, 1023, 1023, 1023, 1023, 0, 0, 0, 600, 700, 800, 900};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, extreme and bit-toggling samples first.
      foreach (directed[i]) send_sample(directed[i]);
      send_runs(126, 10000);

      // Threshold beyond the reachable range, zero limit and zero divisor.
      run_setting(16'hFFFF, 0, 0, 8, 67, 125, 1'b0);
      // Never low: the counter only decays, and the alarm drops out once it reaches the floor.
      run_setting(0, 65535, 1000, 8, 67, 125, 1'b0);
      drain();
      write_reg(CSR_UNUSED, 16'h1234);
      csr_valid <= 1'b0;
      // Small limit no higher than the current count, with a long result stall.
      run_setting(9500, 3, 1, 67, 8, 125, 1'b1);
      run_setting(20000, 1, 37, 67, 8, 125, 1'b0);
      run_setting(12000, 2, 16'hFFFF, 67, 8, 125, 1'b0);
      run_setting($urandom_range(8000, 14000), $urandom_range(0, 20),
                  $urandom_range(1, 1000), 0, 0, 125, 1'b0);

      drain();
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[battery_voltage_alarm_top.f]
rtl/bva_pkg.sv
rtl/bva_divider.sv
rtl/bva_datapath.sv
rtl/bva_ctrl.sv
rtl/battery_voltage_alarm_top.sv
tb/sv/bva_checker.sv
tb/sv/testbench.sv
